// ----- rtl/kbde_pkg.sv -----
// ----------------------------------------------------------------------------
// kbde_pkg
// Shared types and constants for the keyboard report to key event converter.
// ----------------------------------------------------------------------------
package kbde_pkg;

    localparam int KEY_SLOTS      = 6;
    localparam int IN_SLOTS       = 6;
    localparam int SCANCODE_COUNT = 256;
    localparam int MOD_COUNT      = 8;
    localparam int MOD_W          = $clog2(MOD_COUNT);
    localparam int SCAN_W         = 8;
    localparam int KEY_W          = 10;
    localparam int MAP_ADDR_W     = $clog2(SCANCODE_COUNT);

    localparam logic [SCAN_W-1:0] MOD_BASE     = SCAN_W'(224);
    localparam logic [SCAN_W-1:0] LOW_CODE_MAX = SCAN_W'(3);

    // modifier steps, two candidate steps per slot, then one end marker
    localparam int STEP_END = MOD_COUNT + 2 * KEY_SLOTS;
    localparam int STEP_W   = $clog2(STEP_END + 1);
    localparam int SLOT_W   = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_REPORT    = 1'b0,
        OP_MAP_WRITE = 1'b1
    } op_t;

    typedef struct packed {
        op_t                                op;
        logic [7:0]                         mods;
        logic [KEY_SLOTS-1:0][SCAN_W-1:0]   prev_keys;
        logic [KEY_SLOTS-1:0][SCAN_W-1:0]   now_keys;
        logic [KEY_SLOTS-1:0]               gone_ok;
        logic [KEY_SLOTS-1:0]               come_ok;
        logic [MAP_ADDR_W-1:0]              map_index;
        logic [KEY_W-1:0]                   map_value;
    } cmd_t;

endpackage

// ----- rtl/kbde_front.sv -----
// ----------------------------------------------------------------------------
// kbde_front
// Accepts transactions, tracks the held keys and classifies slot changes.
// ----------------------------------------------------------------------------
module kbde_front
    import kbde_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic              operation,
    input  logic [7:0]        modifier_bits,
    input  logic [SCAN_W-1:0] key_slot0,
    input  logic [SCAN_W-1:0] key_slot1,
    input  logic [SCAN_W-1:0] key_slot2,
    input  logic [SCAN_W-1:0] key_slot3,
    input  logic [SCAN_W-1:0] key_slot4,
    input  logic [SCAN_W-1:0] key_slot5,
    input  logic [7:0]        map_index,
    input  logic [KEY_W-1:0]  map_value,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output cmd_t              cmd
);

    logic [KEY_SLOTS-1:0][SCAN_W-1:0] prev_keys_reg;
    logic [IN_SLOTS-1:0][SCAN_W-1:0]  in_keys;
    logic [KEY_SLOTS-1:0][SCAN_W-1:0] now_keys;
    logic [KEY_SLOTS-1:0]             gone_ok;
    logic [KEY_SLOTS-1:0]             come_ok;
    logic                             accept;

    assign in_keys = {key_slot5, key_slot4, key_slot3, key_slot2, key_slot1, key_slot0};

    always_comb
    begin
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            now_keys[i] = (i < IN_SLOTS) ? in_keys[i % IN_SLOTS] : '0;
        end
    end

    always_comb
    begin
        logic in_now;
        logic in_prev;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            in_now  = 1'b0;
            in_prev = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++)
            begin
                in_now  = in_now  | (now_keys[j] == prev_keys_reg[i]);
                in_prev = in_prev | (prev_keys_reg[j] == now_keys[i]);
            end
            gone_ok[i] = (prev_keys_reg[i] > LOW_CODE_MAX) && !in_now;
            come_ok[i] = (now_keys[i] > LOW_CODE_MAX) && !in_prev;
        end
    end

    assign item_ready = cmd_ready;
    assign cmd_valid  = item_valid;
    assign accept     = item_valid && cmd_ready;

    always_comb
    begin
        cmd.op        = op_t'(operation);
        cmd.mods      = modifier_bits;
        cmd.prev_keys = prev_keys_reg;
        cmd.now_keys  = now_keys;
        cmd.gone_ok   = gone_ok;
        cmd.come_ok   = come_ok;
        cmd.map_index = MAP_ADDR_W'(map_index);
        cmd.map_value = map_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_keys_reg <= '0;
        end
        else if (accept && (op_t'(operation) == OP_REPORT))
        begin
            prev_keys_reg <= now_keys;
        end
    end

endmodule

// ----- rtl/kbde_queue.sv -----
// ----------------------------------------------------------------------------
// kbde_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module kbde_queue
    import kbde_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// ----- rtl/kbde_back.sv -----
// ----------------------------------------------------------------------------
// kbde_back
// Steps through each report, looks up the keymap and emits key events.
// ----------------------------------------------------------------------------
module kbde_back
    import kbde_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    output logic              event_valid,
    input  logic              event_ready,
    output logic [SCAN_W-1:0] scan_code,
    output logic [KEY_W-1:0]  key_code,
    output logic              pressed,
    output logic              last
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [STEP_W-1:0] step_reg;

    logic              rd_valid_reg;
    logic              rd_end_reg;
    logic              rd_mod_reg;
    logic              rd_cand_reg;
    logic              rd_dir_reg;
    logic [SCAN_W-1:0] rd_code_reg;
    logic [KEY_W-1:0]  rdata_reg;

    logic              hold_valid_reg;
    logic [SCAN_W-1:0] hold_code_reg;
    logic [KEY_W-1:0]  hold_key_reg;
    logic              hold_dir_reg;

    logic              out_valid_reg;
    logic [SCAN_W-1:0] out_code_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic              out_dir_reg;
    logic              out_last_reg;

    logic [KEY_W-1:0]  keymap_mem [SCANCODE_COUNT];

    logic              en;
    logic              at_end;
    logic              free;
    logic              pop;
    logic              map_wr;
    logic [STEP_W-1:0] k;
    logic [SLOT_W-1:0] slot;
    logic              s_mod;
    logic              s_end;
    logic              s_cand;
    logic              s_dir;
    logic [SCAN_W-1:0] s_code;
    logic              new_event;

    assign en        = !out_valid_reg || event_ready;
    assign at_end    = (state_reg == ST_RUN) && (step_reg == STEP_W'(STEP_END));
    assign free      = (state_reg == ST_IDLE) || at_end;
    assign cmd_ready = en && free;
    assign pop       = cmd_ready && cmd_valid;
    assign map_wr    = pop && (cmd.op == OP_MAP_WRITE);

    assign k    = step_reg - STEP_W'(MOD_COUNT);
    assign slot = k[SLOT_W:1];

    always_comb
    begin
        s_mod  = 1'b0;
        s_end  = 1'b0;
        s_cand = 1'b0;
        s_dir  = 1'b0;
        s_code = '0;
        if (step_reg < STEP_W'(MOD_COUNT))
        begin
            s_mod  = 1'b1;
            s_cand = 1'b1;
            s_code = MOD_BASE + SCAN_W'(step_reg[MOD_W-1:0]);
            s_dir  = cmd_reg.mods[step_reg[MOD_W-1:0]];
        end
        else if (step_reg < STEP_W'(STEP_END))
        begin
            if (!k[0])
            begin
                s_code = cmd_reg.prev_keys[slot];
                s_cand = cmd_reg.gone_ok[slot];
                s_dir  = 1'b0;
            end
            else
            begin
                s_code = cmd_reg.now_keys[slot];
                s_cand = cmd_reg.come_ok[slot];
                s_dir  = 1'b1;
            end
        end
        else
        begin
            s_end = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_wr)
        begin
            keymap_mem[cmd.map_index] <= cmd.map_value;
        end
        if (en)
        begin
            rdata_reg <= keymap_mem[MAP_ADDR_W'(s_code)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else if (en)
        begin
            if (pop && (cmd.op == OP_REPORT))
            begin
                state_reg <= ST_RUN;
                step_reg  <= '0;
            end
            else if (at_end)
            begin
                state_reg <= ST_IDLE;
                step_reg  <= '0;
            end
            else if (state_reg == ST_RUN)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && (cmd.op == OP_REPORT))
        begin
            cmd_reg <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rd_valid_reg <= (state_reg == ST_RUN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_end_reg  <= s_end;
            rd_mod_reg  <= s_mod;
            rd_cand_reg <= s_cand;
            rd_dir_reg  <= s_dir;
            rd_code_reg <= s_code;
        end
    end

    assign new_event = rd_valid_reg && !rd_end_reg
                       && (rd_mod_reg || (rd_cand_reg && (rdata_reg != '0)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            if (rd_valid_reg && rd_end_reg)
            begin
                hold_valid_reg <= 1'b0;
                out_valid_reg  <= hold_valid_reg;
            end
            else if (new_event)
            begin
                hold_valid_reg <= 1'b1;
                out_valid_reg  <= hold_valid_reg;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rd_valid_reg && (rd_end_reg || new_event))
            begin
                out_code_reg <= hold_code_reg;
                out_key_reg  <= hold_key_reg;
                out_dir_reg  <= hold_dir_reg;
                out_last_reg <= rd_end_reg;
            end
            if (new_event)
            begin
                hold_code_reg <= rd_code_reg;
                hold_key_reg  <= rdata_reg;
                hold_dir_reg  <= rd_dir_reg;
            end
        end
    end

    assign event_valid = out_valid_reg;
    assign scan_code   = out_code_reg;
    assign key_code    = out_key_reg;
    assign pressed     = out_dir_reg;
    assign last        = out_last_reg;

`ifndef SYNTH
    a_hold_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_valid_reg && rd_end_reg) |-> hold_valid_reg)
        else $error("report ended with no pending event");

    a_last_emitted: assert property (@(posedge clk) disable iff (!rst_n)
        (en && rd_valid_reg && rd_end_reg) |=> (event_valid && last))
        else $error("end of report did not emit final event");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (step_reg <= STEP_W'(STEP_END)))
        else $error("step counter out of range");
`endif

endmodule

// ----- rtl/keyboard_report_diff_events.sv -----
// ----------------------------------------------------------------------------
// keyboard_report_diff_events
// Keyboard reports in, per-key press and release events out.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  item    | item_valid / item_ready    | operation, modifier_bits, key_slot0..5,
//          |                            | map_index, map_value
//  event   | event_valid / event_ready  | scan_code, key_code, pressed, last
//
//  A report passes through the back sequencer with one keymap read per step:
//  8 modifier steps, 2 steps per key slot and one end step; map writes use no step.
//  The keymap port and the output register set the pace; events that do not
//  fire still use their step. A 2-entry command queue lets the front keep
//  accepting while the back stalls. Reset clears the held keys and control;
//  the keymap is not cleared.
// ----------------------------------------------------------------------------
module keyboard_report_diff_events
    import kbde_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic              operation,
    input  logic [7:0]        modifier_bits,
    input  logic [SCAN_W-1:0] key_slot0,
    input  logic [SCAN_W-1:0] key_slot1,
    input  logic [SCAN_W-1:0] key_slot2,
    input  logic [SCAN_W-1:0] key_slot3,
    input  logic [SCAN_W-1:0] key_slot4,
    input  logic [SCAN_W-1:0] key_slot5,
    input  logic [7:0]        map_index,
    input  logic [KEY_W-1:0]  map_value,
    output logic              event_valid,
    input  logic              event_ready,
    output logic [SCAN_W-1:0] scan_code,
    output logic [KEY_W-1:0]  key_code,
    output logic              pressed,
    output logic              last
);

    logic fq_valid;
    logic fq_ready;
    cmd_t fq_cmd;
    logic qb_valid;
    logic qb_ready;
    cmd_t qb_cmd;

    kbde_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .operation     (operation),
        .modifier_bits (modifier_bits),
        .key_slot0     (key_slot0),
        .key_slot1     (key_slot1),
        .key_slot2     (key_slot2),
        .key_slot3     (key_slot3),
        .key_slot4     (key_slot4),
        .key_slot5     (key_slot5),
        .map_index     (map_index),
        .map_value     (map_value),
        .cmd_valid     (fq_valid),
        .cmd_ready     (fq_ready),
        .cmd           (fq_cmd)
    );

    kbde_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_cmd   (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_cmd    (qb_cmd)
    );

    kbde_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (qb_valid),
        .cmd_ready   (qb_ready),
        .cmd         (qb_cmd),
        .event_valid (event_valid),
        .event_ready (event_ready),
        .scan_code   (scan_code),
        .key_code    (key_code),
        .pressed     (pressed),
        .last        (last)
    );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for keyboard_report_diff_events. Loads the whole keymap, walks a
// table of directed reports and map writes, then sends randomized report
// sequences in three idle modes. Every event is checked against a predictor
// of the modifier and slot-diff logic; directed reports also check the event
// count between sync points.
// ----------------------------------------------------------------------------
module tb;
    import kbde_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 153;
    localparam int PHASES       = 3;
    localparam int SETTLE       = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 250;
    localparam int DRAIN_AT     = 25;
    localparam int MAX_CYCLES   = 500000;
    localparam int NO_COUNT     = -1;
    localparam int KEYS_W       = KEY_SLOTS * SCAN_W;

    typedef struct packed {
        op_t                              op;
        logic [7:0]                       mods;
        logic [KEY_SLOTS-1:0][SCAN_W-1:0] keys;
        logic [7:0]                       idx;
        logic [KEY_W-1:0]                 val;
    } key_item_t;

    typedef struct packed {
        logic [SCAN_W-1:0] scan;
        logic [KEY_W-1:0]  key;
        logic              pressed;
        logic              last;
    } key_event_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              item_valid    = 1'b0;
    logic              item_ready;
    logic              operation     = 1'b0;
    logic [7:0]        modifier_bits = '0;
    logic [SCAN_W-1:0] key_slot0     = '0;
    logic [SCAN_W-1:0] key_slot1     = '0;
    logic [SCAN_W-1:0] key_slot2     = '0;
    logic [SCAN_W-1:0] key_slot3     = '0;
    logic [SCAN_W-1:0] key_slot4     = '0;
    logic [SCAN_W-1:0] key_slot5     = '0;
    logic [7:0]        map_index     = '0;
    logic [KEY_W-1:0]  map_value     = '0;
    logic              event_valid;
    logic              event_ready   = 1'b0;
    logic [SCAN_W-1:0] scan_code;
    logic [KEY_W-1:0]  key_code;
    logic              pressed;
    logic              last;

    // predictor state
    logic [KEY_W-1:0]                 keymap_shadow [SCANCODE_COUNT];
    logic [KEY_SLOTS-1:0][SCAN_W-1:0] held_keys = '0;

    key_event_t expected_events [$];
    int         report_sizes [$];
    key_item_t  directed_items [$];
    int         directed_sizes [$];

    logic [KEY_SLOTS-1:0][SCAN_W-1:0] sent_keys = '0;

    int mismatches       = 0;
    int cycles           = 0;
    int events_seen      = 0;
    int events_in_report = 0;
    int idle_mode        = 2;
    int hold_left        = 0;
    bit hold_done        = 1'b0;

    key_event_t got_want;
    int         size_want;

    keyboard_report_diff_events u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .operation     (operation),
        .modifier_bits (modifier_bits),
        .key_slot0     (key_slot0),
        .key_slot1     (key_slot1),
        .key_slot2     (key_slot2),
        .key_slot3     (key_slot3),
        .key_slot4     (key_slot4),
        .key_slot5     (key_slot5),
        .map_index     (map_index),
        .map_value     (map_value),
        .event_valid   (event_valid),
        .event_ready   (event_ready),
        .scan_code     (scan_code),
        .key_code      (key_code),
        .pressed       (pressed),
        .last          (last)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d events pending", cycles,
                     expected_events.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic int tx_idle_pct();
        return (idle_mode == 0) ? 18 : (idle_mode == 1) ? 45 : 0;
    endfunction

    function automatic int rx_stall_pct();
        return (idle_mode == 0) ? 45 : (idle_mode == 1) ? 18 : 0;
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        $display("mismatch %s: expected %0d got %0d (t=%0t)", what, want, got, $time);
        mismatches++;
    endtask

    function automatic bit holds_code(input logic [KEY_SLOTS-1:0][SCAN_W-1:0] set,
                                      input logic [SCAN_W-1:0] code);
        for (int i = 0; i < KEY_SLOTS; i++)
            if (set[i] == code)
                return 1'b1;
        return 1'b0;
    endfunction

    // modifier events first, then release/press per slot; last event is the sync point
    function automatic void predict_events(input key_item_t it);
        key_event_t                       batch [MOD_COUNT + 2 * KEY_SLOTS];
        logic [KEY_SLOTS-1:0][SCAN_W-1:0] cur;
        logic [SCAN_W-1:0]                gone;
        logic [SCAN_W-1:0]                come;
        int                               n;
        if (it.op == OP_MAP_WRITE)
        begin
            keymap_shadow[it.idx] = it.val;
            return;
        end
        cur = it.keys;
        n = 0;
        for (int i = 0; i < MOD_COUNT; i++)
        begin
            batch[n].scan    = MOD_BASE + SCAN_W'(i);
            batch[n].key     = keymap_shadow[MOD_BASE + SCAN_W'(i)];
            batch[n].pressed = it.mods[i];
            batch[n].last    = 1'b0;
            n++;
        end
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            gone = held_keys[i];
            come = cur[i];
            if (gone > LOW_CODE_MAX && !holds_code(cur, gone) && keymap_shadow[gone] != 0)
            begin
                batch[n] = '{scan: gone, key: keymap_shadow[gone], pressed: 1'b0, last: 1'b0};
                n++;
            end
            if (come > LOW_CODE_MAX && !holds_code(held_keys, come) && keymap_shadow[come] != 0)
            begin
                batch[n] = '{scan: come, key: keymap_shadow[come], pressed: 1'b1, last: 1'b0};
                n++;
            end
        end
        batch[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_events.push_back(batch[i]);
        held_keys = cur;
    endfunction

    function automatic void add_row(input op_t op, input logic [7:0] mods,
                                    input logic [7:0] k0, input logic [7:0] k1,
                                    input logic [7:0] k2, input logic [7:0] k3,
                                    input logic [7:0] k4, input logic [7:0] k5,
                                    input logic [7:0] idx, input logic [KEY_W-1:0] val,
                                    input int want_n);
        key_item_t it;
        it.op      = op;
        it.mods    = mods;
        it.keys[0] = k0;
        it.keys[1] = k1;
        it.keys[2] = k2;
        it.keys[3] = k3;
        it.keys[4] = k4;
        it.keys[5] = k5;
        it.idx     = idx;
        it.val     = val;
        directed_items.push_back(it);
        directed_sizes.push_back(want_n);
    endfunction

    // mostly evolving reports built on the last one sent, plus map writes and noise
    function automatic key_item_t random_item();
        key_item_t it;
        int        roll;
        int        pick;
        int        a;
        int        b;
        logic [7:0] t;
        it.op   = OP_REPORT;
        it.mods = 8'($urandom);
        it.idx  = 8'($urandom);
        it.val  = KEY_W'($urandom);
        it.keys = sent_keys;
        roll = $urandom_range(0, 99);
        if (roll < 12)
        begin
            it.op   = OP_MAP_WRITE;
            it.keys = KEYS_W'({$urandom, $urandom});
            if ($urandom_range(0, 2) != 0)
                it.idx = 8'($urandom_range(0, 20));
            pick = $urandom_range(0, 99);
            if (pick < 25)
                it.val = '0;
            else if (pick < 35)
                it.val = '1;
        end
        else if (roll < 20)
            it.keys = KEYS_W'({$urandom, $urandom});
        else if (roll < 24)
            it.keys = '0;
        else
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                if ($urandom_range(0, 99) < 30)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 55)
                        it.keys[i] = SCAN_W'($urandom_range(0, 20));
                    else if (pick < 75)
                        it.keys[i] = SCAN_W'($urandom_range(224, 231));
                    else
                        it.keys[i] = SCAN_W'($urandom_range(0, 255));
                end
            end
            if ($urandom_range(0, 99) < 20)
            begin
                a = $urandom_range(0, KEY_SLOTS - 1);
                b = $urandom_range(0, KEY_SLOTS - 1);
                t = it.keys[a];
                it.keys[a] = it.keys[b];
                it.keys[b] = t;
            end
        end
        if (it.op == OP_REPORT)
            sent_keys = it.keys;
        return it;
    endfunction

    task automatic send_item(input key_item_t it, input int want_n);
        while ($urandom_range(0, 99) < tx_idle_pct())
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid    <= 1'b1;
        operation     <= it.op;
        modifier_bits <= it.mods;
        key_slot0     <= it.keys[0];
        key_slot1     <= it.keys[1];
        key_slot2     <= it.keys[2];
        key_slot3     <= it.keys[3];
        key_slot4     <= it.keys[4];
        key_slot5     <= it.keys[5];
        map_index     <= it.idx;
        map_value     <= it.val;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predict_events(it);
        if (it.op == OP_REPORT)
            report_sizes.push_back(want_n);
    endtask

    task automatic drain_events();
        item_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // receiver: random stalls, plus one long hold-off so the input side backs up
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            event_ready <= 1'b0;
            hold_left--;
        end
        else if (!hold_done && events_seen >= HOLD_AFTER)
        begin
            event_ready <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        else
            event_ready <= ($urandom_range(0, 99) >= rx_stall_pct());
    end

    always @(posedge clk)
    begin
        if (rst_n && event_valid && event_ready)
        begin
            events_seen++;
            events_in_report++;
            if (expected_events.size() == 0)
                flag_mismatch("unexpected event scan_code", NO_COUNT, scan_code);
            else
            begin
                got_want = expected_events.pop_front();
                if (scan_code !== got_want.scan)
                    flag_mismatch("scan_code", got_want.scan, scan_code);
                if (key_code !== got_want.key)
                    flag_mismatch("key_code", got_want.key, key_code);
                if (pressed !== got_want.pressed)
                    flag_mismatch("pressed", got_want.pressed, pressed);
                if (last !== got_want.last)
                    flag_mismatch("last", got_want.last, last);
            end
            if (last === 1'b1)
            begin
                if (report_sizes.size() != 0)
                begin
                    size_want = report_sizes.pop_front();
                    if (size_want != NO_COUNT && size_want != events_in_report)
                        flag_mismatch("events per report", size_want, events_in_report);
                end
                events_in_report = 0;
            end
        end
    end

    initial
    begin
        key_item_t it;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every keymap entry is written before any report can read it
        idle_mode = 2;
        for (int i = 0; i < SCANCODE_COUNT; i++)
        begin
            it      = '0;
            it.op   = OP_MAP_WRITE;
            it.idx  = 8'(i);
            it.val  = KEY_W'($urandom_range(1, 1023));
            it.keys = KEYS_W'({$urandom, $urandom});
            it.mods = 8'($urandom);
            send_item(it, NO_COUNT);
        end
        drain_events();

        //      op            mods   slot0..slot5                    idx    val   events
        add_row(OP_MAP_WRITE, 8'h00, 0,   0,   0,   0,   0,   0,   8'd4,   0,    NO_COUNT);
        add_row(OP_MAP_WRITE, 8'hFF, 255, 255, 255, 255, 255, 255, 8'd255, 1023, NO_COUNT);
        add_row(OP_MAP_WRITE, 8'h00, 0,   0,   0,   0,   0,   0,   8'd224, 0,    NO_COUNT);
        add_row(OP_MAP_WRITE, 8'h00, 0,   0,   0,   0,   0,   0,   8'd5,   1,    NO_COUNT);
        add_row(OP_MAP_WRITE, 8'h00, 0,   0,   0,   0,   0,   0,   8'd0,   1023, NO_COUNT);
        add_row(OP_REPORT,    8'h00, 0,   0,   0,   0,   0,   0,   8'd0,   0,    8);
        add_row(OP_REPORT,    8'hFF, 0,   0,   0,   0,   0,   0,   8'd255, 1023, 8);
        add_row(OP_REPORT,    8'h55, 255, 5,   6,   7,   8,   9,   8'd0,   0,    14);
        add_row(OP_REPORT,    8'h55, 255, 5,   6,   7,   8,   9,   8'd0,   0,    8);
        add_row(OP_REPORT,    8'hAA, 4,   5,   6,   7,   8,   9,   8'd0,   0,    9);
        add_row(OP_REPORT,    8'h01, 1,   2,   3,   0,   0,   0,   8'd0,   0,    13);
        add_row(OP_REPORT,    8'h80, 9,   8,   7,   6,   5,   255, 8'd0,   0,    14);
        add_row(OP_REPORT,    8'h0F, 5,   6,   7,   8,   9,   255, 8'd0,   0,    8);
        add_row(OP_REPORT,    8'hF0, 10,  11,  12,  13,  14,  15,  8'd0,   0,    20);
        add_row(OP_REPORT,    8'h00, 10,  10,  10,  10,  10,  10,  8'd0,   0,    13);
        add_row(OP_REPORT,    8'h3C, 224, 231, 128, 0,   0,   0,   8'd0,   0,    16);
        add_row(OP_MAP_WRITE, 8'h00, 0,   0,   0,   0,   0,   0,   8'd128, 0,    NO_COUNT);
        add_row(OP_REPORT,    8'hC3, 224, 231, 128, 0,   0,   0,   8'd0,   0,    8);
        add_row(OP_REPORT,    8'h80, 0,   0,   0,   0,   0,   0,   8'd0,   0,    9);
        add_row(OP_REPORT,    8'h00, 3,   4,   255, 224, 128, 254, 8'd77,  513,  10);

        idle_mode = 0;
        for (int i = 0; i < directed_items.size(); i++)
            send_item(directed_items[i], directed_sizes[i]);
        sent_keys = held_keys;
        drain_events();

        for (int p = 0; p < PHASES; p++)
        begin
            idle_mode = p;
            for (int k = 0; k < RANDOM_ITEMS / PHASES; k++)
            begin
                if (p == 1 && k == DRAIN_AT)
                    drain_events();
                send_item(random_item(), NO_COUNT);
            end
            drain_events();
        end

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/kbde_pkg.sv
rtl/kbde_front.sv
rtl/kbde_queue.sv
rtl/kbde_back.sv
rtl/keyboard_report_diff_events.sv
verif/tb.sv
